@@ hdl/cpf_pkg.sv @@
`default_nettype none
package cpf_pkg;

   // Curve parameter format and point budget
   localparam int T_FRAC_BITS = 16;
   localparam int MAX_POINTS  = 64;
   localparam int HW          = 40;   // width of polynomial coefficients and Horner terms
   localparam int CNT_W       = $clog2(MAX_POINTS);
   localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
   localparam int DT_MIN_INT  = ((1 << T_FRAC_BITS) + MAX_POINTS - 1) / MAX_POINTS;
   localparam logic [T_FRAC_BITS-1:0] DT_MIN = T_FRAC_BITS'(DT_MIN_INT);
   localparam logic [CNT_W-1:0] PT_LIMIT = CNT_W'(MAX_POINTS - 1);
   localparam logic [31:0] SQRT8_Q30 = 32'd3037000500;
   localparam logic [15:0] TOL_RESET = 16'd64;
   localparam int FIFO_DEPTH  = 2;

   typedef enum logic [1:0] {
      OP_MOVE  = 2'd0,
      OP_LINE  = 2'd1,
      OP_CUBIC = 2'd2,
      OP_CLOSE = 2'd3
   } opcode_type;

   // One classified command as it travels from front to back
   typedef struct packed {
      opcode_type             op;
      logic signed [31:0]     p0x;
      logic signed [31:0]     p0y;
      logic signed [31:0]     endx;
      logic signed [31:0]     endy;
      logic signed [HW-1:0]   ax;
      logic signed [HW-1:0]   ay;
      logic signed [HW-1:0]   bx;
      logic signed [HW-1:0]   by;
      logic signed [HW-1:0]   cx;
      logic signed [HW-1:0]   cy;
      logic signed [HW-1:0]   sx;
      logic signed [HW-1:0]   sy;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SQ,
      ST_SMAX,
      ST_SQRT1,
      ST_NUM,
      ST_CMP,
      ST_DIV,
      ST_SQRT2,
      ST_PT_CHECK,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_EMIT_PT,
      ST_EMIT_END,
      ST_EMIT_CLOSE
   } state_type;

   function automatic logic [HW-1:0] mag_hw(input logic signed [HW-1:0] v);
      mag_hw = v[HW-1] ? HW'(-v) : HW'(v);
   endfunction

   // v * t / ONE, rounded to nearest, ties away from zero
   function automatic logic signed [HW-1:0] mul_t(input logic signed [HW-1:0] v,
                                                  input logic [T_FRAC_BITS-1:0] t);
      logic [HW-1:0]             m;
      logic [HW+T_FRAC_BITS-1:0] p;
      logic [HW+T_FRAC_BITS-1:0] rnd;
      logic [HW+T_FRAC_BITS-1:0] r;
      m   = mag_hw(v);
      p   = {{T_FRAC_BITS{1'b0}}, m} * {{HW{1'b0}}, t};
      rnd = {{HW{1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};
      r   = (p + rnd) >> T_FRAC_BITS;
      mul_t = v[HW-1] ? -$signed(r[HW-1:0]) : $signed(r[HW-1:0]);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [HW-1:0] v);
      if (!v[HW-1] && (|v[HW-2:31])) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (v[HW-1] && !(&v[HW-2:31])) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ hdl/cpf_isqrt.sv @@
`default_nettype none
module cpf_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             done,
   output logic [31:0]      root
);
   import cpf_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [35:0] rem_sh;
   logic [35:0] trial;

   // Two radicand bits per step, one root bit per step
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, val_ff[63:62]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[61:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = rem_sh[33:0];
            root_in = {root_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

@@ hdl/cpf_front.sv @@
`default_nettype none
module cpf_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_ctrl1_x,
   input  wire logic signed [31:0] req_ctrl1_y,
   input  wire logic signed [31:0] req_ctrl2_x,
   input  wire logic signed [31:0] req_ctrl2_y,
   input  wire logic signed [31:0] req_end_x,
   input  wire logic signed [31:0] req_end_y,
   input  wire logic               fifo_full,
   output logic                    push,
   output cpf_pkg::cmd_type        push_data
);
   import cpf_pkg::*;

   logic signed [31:0]   cur_x_ff, cur_x_in;
   logic signed [31:0]   cur_y_ff, cur_y_in;
   logic signed [HW-1:0] e0x, e0y, e1x, e1y, e2x, e2y, e3x, e3y;
   logic signed [HW-1:0] ax, ay, bx, by;
   opcode_type           op;

   assign req_ready = !fifo_full;
   assign push      = req_valid && req_ready;
   assign op        = opcode_type'(req_opcode);

   // Power-basis coefficients against the current point
   always_comb begin
      e0x = HW'(cur_x_ff);
      e0y = HW'(cur_y_ff);
      e1x = HW'(req_ctrl1_x);
      e1y = HW'(req_ctrl1_y);
      e2x = HW'(req_ctrl2_x);
      e2y = HW'(req_ctrl2_y);
      e3x = HW'(req_end_x);
      e3y = HW'(req_end_y);
      ax  = -e0x + ((e1x <<< 1) + e1x) - ((e2x <<< 1) + e2x) + e3x;
      ay  = -e0y + ((e1y <<< 1) + e1y) - ((e2y <<< 1) + e2y) + e3y;
      bx  = ((e0x <<< 1) + e0x) - ((e1x <<< 2) + (e1x <<< 1)) + ((e2x <<< 1) + e2x);
      by  = ((e0y <<< 1) + e0y) - ((e1y <<< 2) + (e1y <<< 1)) + ((e2y <<< 1) + e2y);
      push_data.op   = op;
      push_data.p0x  = cur_x_ff;
      push_data.p0y  = cur_y_ff;
      push_data.endx = req_end_x;
      push_data.endy = req_end_y;
      push_data.ax   = ax;
      push_data.ay   = ay;
      push_data.bx   = bx;
      push_data.by   = by;
      push_data.cx   = ((e1x <<< 1) + e1x) - ((e0x <<< 1) + e0x);
      push_data.cy   = ((e1y <<< 1) + e1y) - ((e0y <<< 1) + e0y);
      push_data.sx   = ax + bx;
      push_data.sy   = ay + by;
   end

   // Current point follows every command but close
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (push && (op != OP_CLOSE)) begin
         cur_x_in = req_end_x;
         cur_y_in = req_end_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/cpf_fifo.sv @@
`default_nettype none
module cpf_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cpf_pkg::cmd_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output cpf_pkg::cmd_type       pop_data,
   output logic                   empty
);
   import cpf_pkg::*;

   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);

   cmd_type         mem_ff [FIFO_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == CW'(FIFO_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("fifo written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("fifo read while empty");
`endif

endmodule
`default_nettype wire

@@ hdl/cpf_back.sv @@
`default_nettype none
module cpf_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [15:0]       csr_wr_data,
   input  wire logic              fifo_empty,
   input  wire cpf_pkg::cmd_type  fifo_data,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic signed [31:0]     rsp_out_x,
   output logic signed [31:0]     rsp_out_y,
   output logic                   rsp_last_point
);
   import cpf_pkg::*;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [15:0]             tol_ff, tol_in;
   logic [61:0]             sq_ff, sq_in;
   logic [62:0]             sb_ff, sb_in;
   logic [62:0]             ss_ff, ss_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [31:0]             conc_ff, conc_in;
   logic [47:0]             num_ff, num_in;
   logic [63:0]             rem_ff, rem_in;
   logic [31:0]             quo_ff, quo_in;
   logic [T_FRAC_BITS-1:0]  dt_ff, dt_in;
   logic [T_FRAC_BITS:0]    t_ff, t_in;
   logic [CNT_W-1:0]        n_ff, n_in;
   logic signed [HW-1:0]    hx_ff, hx_in;
   logic signed [HW-1:0]    hy_ff, hy_in;
   logic signed [31:0]      first_x_ff, first_x_in;
   logic signed [31:0]      first_y_ff, first_y_in;
   logic signed [31:0]      prev_x_ff, prev_x_in;
   logic signed [31:0]      prev_y_ff, prev_y_in;
   logic                    has_ff, has_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]      rsp_x_ff, rsp_x_in;
   logic signed [31:0]      rsp_y_ff, rsp_y_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    emit_ok;
   logic                    do_emit;
   logic signed [31:0]      em_x, em_y;
   logic                    em_last;
   logic [HW-1:0]           mag_bx, mag_by, mag_sx, mag_sy;
   logic [HW-1:0]           sq_op;
   logic                    big;
   logic [62:0]             smax;
   logic [61:0]             den;
   logic [63:0]             rem_sh;
   logic                    sqrt_start;
   logic [63:0]             sqrt_value;
   logic                    sqrt_done;
   logic [31:0]             sqrt_root;

   cpf_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign emit_ok = !rsp_valid_ff || rsp_ready;
   assign mag_bx  = mag_hw(cmd_ff.bx);
   assign mag_by  = mag_hw(cmd_ff.by);
   assign mag_sx  = mag_hw(cmd_ff.sx);
   assign mag_sy  = mag_hw(cmd_ff.sy);
   assign big     = (|mag_bx[HW-1:31]) || (|mag_by[HW-1:31]) ||
                    (|mag_sx[HW-1:31]) || (|mag_sy[HW-1:31]);
   assign smax    = (sb_ff > ss_ff) ? sb_ff : ss_ff;
   assign den     = {conc_ff, 30'b0};
   assign rem_sh  = {rem_ff[62:0], 1'b0};

   // Operand of the shared squarer
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = mag_bx;
         2'd1:    sq_op = mag_by;
         2'd2:    sq_op = mag_sx;
         default: sq_op = mag_sy;
      endcase
   end

   // Sequencer: step size setup, Horner evaluation, point emission
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      tol_in     = csr_wr_en ? csr_wr_data : tol_ff;
      sq_in      = sq_ff;
      sb_in      = sb_ff;
      ss_in      = ss_ff;
      cnt_in     = cnt_ff;
      conc_in    = conc_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      dt_in      = dt_ff;
      t_in       = t_ff;
      n_in       = n_ff;
      hx_in      = hx_ff;
      hy_in      = hy_ff;
      pop        = 1'b0;
      do_emit    = 1'b0;
      em_x       = cmd_ff.endx;
      em_y       = cmd_ff.endy;
      em_last    = 1'b1;
      sqrt_start = 1'b0;
      sqrt_value = {1'b0, smax};

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty) begin
               pop      = 1'b1;
               cmd_in   = fifo_data;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (cmd_ff.op) inside
               OP_MOVE, OP_LINE: state_in = ST_EMIT_END;
               OP_CLOSE: begin
                  if (has_ff && ((first_x_ff != prev_x_ff) || (first_y_ff != prev_y_ff))) begin
                     state_in = ST_EMIT_CLOSE;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               default: begin
                  if (big) begin
                     dt_in    = DT_MIN;
                     t_in     = {1'b0, DT_MIN};
                     n_in     = '0;
                     state_in = ST_PT_CHECK;
                  end else begin
                     cnt_in   = '0;
                     sb_in    = '0;
                     ss_in    = '0;
                     state_in = ST_SQ;
                  end
               end
            endcase
         end
         ST_SQ: begin
            // squares of bx, by, sx, sy; each square is registered and accumulated in the following step
            sq_in = {31'b0, sq_op[30:0]} * {31'b0, sq_op[30:0]};
            if (cnt_ff == 5'd1 || cnt_ff == 5'd2) begin
               sb_in = sb_ff + {1'b0, sq_ff};
            end else if (cnt_ff == 5'd3 || cnt_ff == 5'd4) begin
               ss_in = ss_ff + {1'b0, sq_ff};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) begin
               state_in = ST_SMAX;
            end
         end
         ST_SMAX: begin
            if (smax == '0) begin
               state_in = ST_EMIT_END;
            end else begin
               sqrt_start = 1'b1;
               state_in   = ST_SQRT1;
            end
         end
         ST_SQRT1: begin
            if (sqrt_done) begin
               conc_in  = sqrt_root;
               state_in = ST_NUM;
            end
         end
         ST_NUM: begin
            num_in   = {16'b0, SQRT8_Q30} * {32'b0, tol_ff};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if ({14'b0, num_ff} >= den) begin
               state_in = ST_EMIT_END;
            end else begin
               rem_in   = {16'b0, num_ff};
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem_sh >= {2'b00, den}) begin
               rem_in = rem_sh - {2'b00, den};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               sqrt_start = 1'b1;
               sqrt_value = {32'b0, quo_in};
               state_in   = ST_SQRT2;
            end
         end
         ST_SQRT2: begin
            if (sqrt_done) begin
               if (sqrt_root < 32'(DT_MIN)) begin
                  dt_in = DT_MIN;
                  t_in  = {1'b0, DT_MIN};
               end else begin
                  dt_in = sqrt_root[T_FRAC_BITS-1:0];
                  t_in  = {1'b0, sqrt_root[T_FRAC_BITS-1:0]};
               end
               n_in     = '0;
               state_in = ST_PT_CHECK;
            end
         end
         ST_PT_CHECK: begin
            if ((t_ff < T_ONE) && (n_ff < PT_LIMIT)) begin
               state_in = ST_M1;
            end else begin
               state_in = ST_EMIT_END;
            end
         end
         ST_M1: begin
            hx_in    = mul_t(cmd_ff.ax, t_ff[T_FRAC_BITS-1:0]) + cmd_ff.bx;
            hy_in    = mul_t(cmd_ff.ay, t_ff[T_FRAC_BITS-1:0]) + cmd_ff.by;
            state_in = ST_M2;
         end
         ST_M2: begin
            hx_in    = mul_t(hx_ff, t_ff[T_FRAC_BITS-1:0]) + cmd_ff.cx;
            hy_in    = mul_t(hy_ff, t_ff[T_FRAC_BITS-1:0]) + cmd_ff.cy;
            state_in = ST_M3;
         end
         ST_M3: begin
            hx_in    = HW'(sat32(mul_t(hx_ff, t_ff[T_FRAC_BITS-1:0]) + HW'(cmd_ff.p0x)));
            hy_in    = HW'(sat32(mul_t(hy_ff, t_ff[T_FRAC_BITS-1:0]) + HW'(cmd_ff.p0y)));
            state_in = ST_EMIT_PT;
         end
         ST_EMIT_PT: begin
            if (emit_ok) begin
               do_emit  = 1'b1;
               em_x     = hx_ff[31:0];
               em_y     = hy_ff[31:0];
               em_last  = 1'b0;
               t_in     = t_ff + {1'b0, dt_ff};
               n_in     = n_ff + CNT_W'(1);
               state_in = ST_PT_CHECK;
            end
         end
         ST_EMIT_END: begin
            if (emit_ok) begin
               do_emit  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_CLOSE: begin
            if (emit_ok) begin
               do_emit  = 1'b1;
               em_x     = first_x_ff;
               em_y     = first_y_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output beat register and path point bookkeeping
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      first_x_in   = first_x_ff;
      first_y_in   = first_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      has_in       = has_ff;
      if (do_emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = em_x;
         rsp_y_in     = em_y;
         rsp_last_in  = em_last;
         prev_x_in    = em_x;
         prev_y_in    = em_y;
         has_in       = 1'b1;
         if (!has_ff) begin
            first_x_in = em_x;
            first_y_in = em_y;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TOL_RESET;
         first_x_ff   <= '0;
         first_y_ff   <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         has_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         first_x_ff   <= first_x_in;
         first_y_ff   <= first_y_in;
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         has_ff       <= has_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      sq_ff       <= sq_in;
      sb_ff       <= sb_in;
      ss_ff       <= ss_in;
      cnt_ff      <= cnt_in;
      conc_ff     <= conc_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dt_ff       <= dt_in;
      t_ff        <= t_in;
      n_ff        <= n_in;
      hx_ff       <= hx_in;
      hy_ff       <= hy_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

`ifndef SYNTHESIS
   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_M1) |-> (t_ff < T_ONE))
      else $error("curve parameter reached one inside evaluation");
   a_step_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PT_CHECK) |-> (dt_ff >= DT_MIN))
      else $error("step below minimum");
   a_emit_has: assert property (@(posedge clock) disable iff (reset)
      do_emit |=> has_ff)
      else $error("emitted point not recorded");
`endif

endmodule
`default_nettype wire

@@ hdl/cubic_path_flattener.sv @@
// Path flattener: move, line, cubic and close commands in, polyline points out.
// Input channel req_*: one beat per command, accepted when req_valid and
// req_ready are both high. Points are signed 24.8 fixed point.
// Result channel rsp_*: one beat per emitted point; rsp_last_point marks the
// final point of each command. A close with nothing to emit gives no beat.
// csr_wr_en/csr_wr_data write the flatness tolerance (unsigned 8.8); write it
// only while the block is idle.
// Move, line and close go from the queue through dispatch and an emit state into the output register.
// A cubic sets up its step (squarer, two 32-step square roots and a 32-step
// divider; skipped when a coefficient is too wide), then evaluates each point
// in one Horner evaluator; a cubic gives at most 64 points.
// A two-entry queue lets the input side take commands while the back end
// works; a full queue drops req_ready. A stalled receiver holds the output
// register and freezes point generation without losing data.
// Reset clears the current, first and last points and sets the tolerance
// to 64 (a quarter pixel).
`default_nettype none
module cubic_path_flattener (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic signed [31:0] req_ctrl1_x,
   input  wire logic signed [31:0] req_ctrl1_y,
   input  wire logic signed [31:0] req_ctrl2_x,
   input  wire logic signed [31:0] req_ctrl2_y,
   input  wire logic signed [31:0] req_end_x,
   input  wire logic signed [31:0] req_end_y,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic                    rsp_last_point,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data
);
   import cpf_pkg::*;

   logic    push, pop, full, empty;
   cmd_type push_data, pop_data;

   cpf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_ctrl1_x (req_ctrl1_x),
      .req_ctrl1_y (req_ctrl1_y),
      .req_ctrl2_x (req_ctrl2_x),
      .req_ctrl2_y (req_ctrl2_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .fifo_full   (full),
      .push        (push),
      .push_data   (push_data)
   );

   cpf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   cpf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fifo_empty     (empty),
      .fifo_data      (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule
`default_nettype wire

@@ sim/cubic_path_flattener_tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module cubic_path_flattener_tb;
   import cpf_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;
   localparam int LONG_HOLD      = 400;

   typedef struct {
      opcode_type op;
      int         c1x, c1y, c2x, c2y, ex, ey;
   } path_cmd_type;

   typedef struct {
      int x;
      int y;
      bit last;
   } poly_point_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   wire logic         req_ready;
   logic [1:0]        req_opcode = '0;
   logic signed [31:0] req_ctrl1_x = '0, req_ctrl1_y = '0;
   logic signed [31:0] req_ctrl2_x = '0, req_ctrl2_y = '0;
   logic signed [31:0] req_end_x = '0, req_end_y = '0;
   wire logic         rsp_valid;
   logic              rsp_ready = 1'b0;
   wire logic signed [31:0] rsp_out_x, rsp_out_y;
   wire logic         rsp_last_point;
   logic              csr_wr_en = 1'b0;
   logic [15:0]       csr_wr_data = '0;

   cubic_path_flattener u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_ctrl1_x(req_ctrl1_x), .req_ctrl1_y(req_ctrl1_y),
      .req_ctrl2_x(req_ctrl2_x), .req_ctrl2_y(req_ctrl2_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_last_point(rsp_last_point),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   path_cmd_type   pending_cmds[$];
   poly_point_type expected_points[$];
   int          error_count = 0;
   int          req_beats = 0;
   bit          quiet = 1'b0;
   int          long_hold_req = 0;

   // path state mirror
   longint unsigned tol_mirror = 64;
   longint cur_x = 0, cur_y = 0, first_x = 0, first_y = 0, prev_x = 0, prev_y = 0;
   bit     has_points = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic longint unsigned mag64(input longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   // v * t / ONE, nearest, ties away from zero
   function automatic longint scale_by_t(input longint v, input longint unsigned t);
      longint unsigned r;
      r = (mag64(v) * t + (64'd1 << (T_FRAC_BITS - 1))) >> T_FRAC_BITS;
      return v < 0 ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // uniform parameter step; zero means end point only
   function automatic longint unsigned curve_step(input longint bx, input longint by,
                                                  input longint sx, input longint sy);
      longint unsigned dmin, sb, ss, s, conc, num, den, rem, q, dt;
      dmin = ((64'd1 << T_FRAC_BITS) + MAX_POINTS - 1) / MAX_POINTS;
      if (mag64(bx) >= (64'd1 << 31) || mag64(by) >= (64'd1 << 31) ||
          mag64(sx) >= (64'd1 << 31) || mag64(sy) >= (64'd1 << 31)) return dmin;
      sb = mag64(bx) * mag64(bx) + mag64(by) * mag64(by);
      ss = mag64(sx) * mag64(sx) + mag64(sy) * mag64(sy);
      s = sb > ss ? sb : ss;
      if (s == 0) return 0;
      conc = isqrt64(s);
      num = 64'd3037000500 * tol_mirror;
      den = conc << 30;
      if (num >= den) return 0;
      rem = num;
      q = 0;
      for (int i = 0; i < 2 * T_FRAC_BITS; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      dt = isqrt64(q);
      return dt < dmin ? dmin : dt;
   endfunction

   function automatic void push_point(input longint x, input longint y);
      poly_point_type p;
      p.x = int'(x);
      p.y = int'(y);
      p.last = 1'b0;
      if (!has_points) begin
         first_x = x;
         first_y = y;
         has_points = 1'b1;
      end
      prev_x = x;
      prev_y = y;
      expected_points.insert(expected_points.size(), p);
   endfunction

   // expected polyline points for one accepted command
   function automatic void predict_points(input path_cmd_type c);
      longint ax, ay, bx, by, cx, cy, hx, hy;
      longint unsigned dt, t;
      int n, base;
      base = expected_points.size();
      n = 0;
      if (c.op == OP_MOVE || c.op == OP_LINE) begin
         cur_x = c.ex;
         cur_y = c.ey;
         push_point(c.ex, c.ey);
         n = 1;
      end else if (c.op == OP_CUBIC) begin
         ax = -cur_x + 3 * longint'(c.c1x) - 3 * longint'(c.c2x) + c.ex;
         ay = -cur_y + 3 * longint'(c.c1y) - 3 * longint'(c.c2y) + c.ey;
         bx = 3 * cur_x - 6 * longint'(c.c1x) + 3 * longint'(c.c2x);
         by = 3 * cur_y - 6 * longint'(c.c1y) + 3 * longint'(c.c2y);
         cx = -3 * cur_x + 3 * longint'(c.c1x);
         cy = -3 * cur_y + 3 * longint'(c.c1y);
         dt = curve_step(bx, by, ax + bx, ay + by);
         if (dt != 0) begin
            for (t = dt; t < (64'd1 << T_FRAC_BITS) && n < MAX_POINTS - 1; t += dt) begin
               hx = scale_by_t(ax, t) + bx;
               hy = scale_by_t(ay, t) + by;
               hx = scale_by_t(hx, t) + cx;
               hy = scale_by_t(hy, t) + cy;
               hx = clamp32(scale_by_t(hx, t) + cur_x);
               hy = clamp32(scale_by_t(hy, t) + cur_y);
               push_point(hx, hy);
               n++;
            end
         end
         push_point(c.ex, c.ey);
         n++;
         cur_x = c.ex;
         cur_y = c.ey;
      end else begin
         if (has_points && (first_x != prev_x || first_y != prev_y)) begin
            push_point(first_x, first_y);
            n = 1;
         end
      end
      if (n > 0) expected_points[base + n - 1].last = 1'b1;
   endfunction

   // command driver
   int drv_seen = 0;
   int drv_gap = 0;
   always @(negedge clock) begin
      logic nv;
      path_cmd_type c;
      nv = req_valid;
      if (nv && req_beats != drv_seen) begin
         drv_seen = req_beats;
         nv = 1'b0;
      end
      if (!nv && !reset) begin
         if (drv_gap > 0) begin
            drv_gap--;
         end else if (pending_cmds.size() > 0) begin
            if (!quiet && $urandom_range(0, 4) == 0) begin
               drv_gap = $urandom_range(1, 9);
            end else begin
               c = pending_cmds.pop_front();
               req_opcode  <= c.op;
               req_ctrl1_x <= c.c1x;
               req_ctrl1_y <= c.c1y;
               req_ctrl2_x <= c.c2x;
               req_ctrl2_y <= c.c2y;
               req_end_x   <= c.ex;
               req_end_y   <= c.ey;
               nv = 1'b1;
            end
         end
      end
      req_valid <= nv;
   end

   // point receiver, with random gaps and one long hold-off
   int rcv_gap = 0;
   int hold_cnt = 0;
   int hold_seen = 0;
   always @(negedge clock) begin
      logic rdy;
      rdy = 1'b1;
      if (hold_cnt > 0) begin
         hold_cnt--;
         rdy = 1'b0;
      end else if (long_hold_req != hold_seen) begin
         hold_seen = long_hold_req;
         hold_cnt = LONG_HOLD;
         rdy = 1'b0;
      end else if (rcv_gap > 0) begin
         rcv_gap--;
         rdy = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rcv_gap = $urandom_range(1, 9);
         rdy = 1'b0;
      end
      rsp_ready <= rdy;
   end

   // monitor: predict on command beats, check point beats, watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      path_cmd_type c;
      poly_point_type e;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            req_beats++;
            c.op  = opcode_type'(req_opcode);
            c.c1x = req_ctrl1_x;
            c.c1y = req_ctrl1_y;
            c.c2x = req_ctrl2_x;
            c.c2y = req_ctrl2_y;
            c.ex  = req_end_x;
            c.ey  = req_end_y;
            predict_points(c);
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected point (%0d,%0d)", rsp_out_x, rsp_out_y));
            end else begin
               e = expected_points.pop_front();
               if (rsp_out_x !== e.x)
                  report_mismatch($sformatf("out_x %0d, want %0d", rsp_out_x, e.x));
               if (rsp_out_y !== e.y)
                  report_mismatch($sformatf("out_y %0d, want %0d", rsp_out_y, e.y));
               if (rsp_last_point !== e.last)
                  report_mismatch($sformatf("last_point %0b, want %0b", rsp_last_point, e.last));
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("cubic_path_flattener test failed");
            $finish;
         end
      end
   end

   task automatic add_cmd(input opcode_type op, input int c1x, input int c1y,
                          input int c2x, input int c2y, input int ex, input int ey);
      path_cmd_type c;
      c.op = op; c.c1x = c1x; c.c1y = c1y; c.c2x = c2x; c.c2y = c2y;
      c.ex = ex; c.ey = ey;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // mostly modest coordinates, now and then the full range
   function automatic int rand_coord();
      int sh;
      sh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(10, 26);
      return $signed($urandom) >>> sh;
   endfunction

   task automatic add_random(input int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            add_cmd(OP_MOVE, $urandom, $urandom, $urandom, $urandom, rand_coord(), rand_coord());
         else if (r == 1)
            add_cmd(OP_LINE, $urandom, $urandom, $urandom, $urandom, rand_coord(), rand_coord());
         else if (r <= 7)
            add_cmd(OP_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
         else if (r == 8)
            add_cmd(OP_CLOSE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         else
            add_cmd(opcode_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom);
      end
   endtask

   // sender waits for every point, then lets trailing work settle
   task automatic drain_all();
      do begin
         @(posedge clock);
      end while (pending_cmds.size() != 0 || req_valid || expected_points.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [15:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      tol_mirror = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: close on empty path, extremes, flat and huge cubics
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CUBIC, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CLOSE, -1, -1, -1, -1, -1, -1);
      add_cmd(OP_MOVE, -1, -1, -1, -1, 32'sh7FFF_FFFF, 32'sh8000_0000);
      add_cmd(OP_LINE, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF);
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CUBIC, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
              32'sh7FFF_FFFF, 32'sh8000_0000);
      add_cmd(OP_MOVE, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CUBIC, 256, 0, 512, 0, 768, 0);
      add_cmd(OP_CUBIC, 1000, 2000, 3000, -4000, 0, 0);
      add_cmd(OP_CUBIC, 800, 801, 799, 800, 800, 800);
      add_cmd(OP_CUBIC, 12800, 25600, -12800, 25600, 0, 0);
      add_cmd(OP_LINE, 0, 0, 0, 0, 5000, 5000);
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0);
      add_cmd(OP_CUBIC, 32'sh4000_0000, -32'sh4000_0000, 32'sh7000_0000, 32'sh1000_0000,
              -32'sh7000_0000, 32'sh2000_0000);
      add_cmd(OP_LINE, 0, 0, 0, 0, -1, -1);
      add_cmd(OP_CLOSE, 0, 0, 0, 0, 0, 0);
      drain_all();

      write_tolerance(16'd1);
      add_random(25);
      drain_all();

      write_tolerance(16'hFFFF);
      add_cmd(OP_CUBIC, 300, 300, 600, -300, 900, 0);
      add_random(20);
      drain_all();

      // receiver holds off long while commands keep coming
      write_tolerance(16'($urandom_range(1, 65535)));
      long_hold_req++;
      add_random(30);
      drain_all();

      write_tolerance(16'd16);
      quiet = 1'b1;
      add_random(25);
      drain_all();

      if (error_count == 0 && expected_points.size() == 0) begin
         $display("cubic_path_flattener test passed");
      end else begin
         $display("cubic_path_flattener test failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
